>>> design/dis_pkg.sv
package dis_pkg;

  localparam int HANDLE_BITS = 16;
  localparam int KEY_BITS    = 32;
  localparam int MAX_ITEMS_DEFAULT = 32;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] item_handle;
    logic                   item_valid;
    logic [KEY_BITS-1:0]    sort_key;
    logic                   end_of_list;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] out_handle;
    logic [KEY_BITS-1:0]    out_key;
    logic                   last_of_run;
    logic                   list_empty;
    logic                   overflowed;
  } out_result_t;

  // contents of one cell, also what travels between neighbors
  typedef struct packed {
    logic                   occ;
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
  } cell_data_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                   ins;
    logic                   pop;
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
  } cell_ctrl_t;

endpackage

>>> design/dis_cell.sv
module dis_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dis_pkg::cell_ctrl_t ctrl,
  input  dis_pkg::cell_data_t prev_data,
  input  logic               prev_shift,
  input  dis_pkg::cell_data_t next_data,
  output dis_pkg::cell_data_t data,
  output logic               shift
);

  logic                         occ_r, occ_nxt;
  logic [dis_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [dis_pkg::KEY_BITS-1:0]    key_r, key_nxt;

  // this entry moves down one place when the new key beats it
  assign shift = occ_r && (key_r < ctrl.key);

  always_comb begin
    occ_nxt    = occ_r;
    handle_nxt = handle_r;
    key_nxt    = key_r;
    if (ctrl.pop) begin
      occ_nxt    = next_data.occ;
      handle_nxt = next_data.handle;
      key_nxt    = next_data.key;
    end else if (ctrl.ins) begin
      if (prev_shift) begin
        occ_nxt    = prev_data.occ;
        handle_nxt = prev_data.handle;
        key_nxt    = prev_data.key;
      end else if (shift || (!occ_r && prev_data.occ)) begin
        occ_nxt    = 1'b1;
        handle_nxt = ctrl.handle;
        key_nxt    = ctrl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    key_r    <= key_nxt;
  end

  assign data.occ    = occ_r;
  assign data.handle = handle_r;
  assign data.key    = key_r;

endmodule

>>> design/descending_insertion_sorter_core.sv
// channel  ports                         handshake
// in       start, busy, in_item          taken when start && !busy
// out      out_strobe, out_result        one strobe per result, no backpressure
//
// an item is loaded as soon as it is taken: the new key is compared in every cell at
// once and the row shifts by one place below the insert point.
// after the item with end_of_list, the row drains through cell 0, one result
// per cycle (a result per entry, or a single list_empty result for an empty list);
// busy is high meanwhile. each result is registered as it leaves cell 0.
// reset (synchronous, rst_n low) empties the row and clears the overflow mark.
module descending_insertion_sorter_core #(
  parameter int MAX_ITEMS = dis_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  dis_pkg::in_item_t     in_item,
  output logic                  out_strobe,
  output dis_pkg::out_result_t  out_result
);

  dis_pkg::cell_data_t cells [MAX_ITEMS];
  logic                shifts [MAX_ITEMS];
  dis_pkg::cell_ctrl_t ctrl;
  dis_pkg::cell_data_t head_bound, tail_bound;

  logic accept, full, emit_done;
  logic emit_r, emit_nxt;
  logic ovf_r, ovf_nxt;
  logic strobe_r;
  dis_pkg::out_result_t result_r, result_nxt;

  assign accept    = start && !busy;
  assign full      = cells[MAX_ITEMS-1].occ;
  assign emit_done = emit_r && (!cells[0].occ || !cells[1].occ);

  assign ctrl.ins    = accept && in_item.item_valid && !full;
  assign ctrl.pop    = emit_r && cells[0].occ;
  assign ctrl.handle = in_item.item_handle;
  assign ctrl.key    = in_item.sort_key;

  // boundary above cell 0 counts as occupied so an empty row takes the item
  assign head_bound = '{occ: 1'b1, handle: '0, key: '0};
  assign tail_bound = '{occ: 1'b0, handle: '0, key: '0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_first
      dis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .prev_data  (head_bound),
        .prev_shift (1'b0),
        .next_data  (cells[i+1]),
        .data       (cells[i]),
        .shift      (shifts[i])
      );
    end else if (i == MAX_ITEMS-1) begin : g_last
      dis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .prev_data  (cells[i-1]),
        .prev_shift (shifts[i-1]),
        .next_data  (tail_bound),
        .data       (cells[i]),
        .shift      (shifts[i])
      );
    end else begin : g_mid
      dis_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .prev_data  (cells[i-1]),
        .prev_shift (shifts[i-1]),
        .next_data  (cells[i+1]),
        .data       (cells[i]),
        .shift      (shifts[i])
      );
    end
  end

  always_comb begin
    emit_nxt = emit_r;
    if (accept && in_item.end_of_list) begin
      emit_nxt = 1'b1;
    end else if (emit_done) begin
      emit_nxt = 1'b0;
    end
  end

  always_comb begin
    ovf_nxt = ovf_r;
    if (emit_done) begin
      ovf_nxt = 1'b0;
    end else if (accept && in_item.item_valid && full) begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    result_nxt.out_handle  = cells[0].occ ? cells[0].handle : '0;
    result_nxt.out_key     = cells[0].occ ? cells[0].key : '0;
    result_nxt.last_of_run = !cells[0].occ || !cells[1].occ;
    result_nxt.list_empty  = !cells[0].occ;
    result_nxt.overflowed  = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r   <= 1'b0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      emit_r   <= emit_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign busy       = emit_r;
  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule
